// ===== hdl/rvmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rvmt_pkg
// Shared types and constants for the row-vector by 4x4 matrix transform.
// ----------------------------------------------------------------------------
package rvmt_pkg;

  localparam int VEC_LEN       = 4;
  localparam int ELEM_W        = 32;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int SUM_W         = PROD_W + $clog2(VEC_LEN);
  localparam int NUM_REGS      = 8;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 4;
  localparam int REG_IDX_W     = $clog2(NUM_REGS);
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [VEC_LEN-1:0] vec_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] in_x;
    logic signed [ELEM_W-1:0] in_y;
    logic signed [ELEM_W-1:0] in_z;
    logic signed [ELEM_W-1:0] in_w;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_x;
    logic signed [ELEM_W-1:0] out_y;
    logic signed [ELEM_W-1:0] out_z;
    logic signed [ELEM_W-1:0] out_w;
    logic                     saturated;
  } out_t;

  // load enables for the three lane stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } lane_ctl_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              sat;
  } lane_res_t;

endpackage

// ===== hdl/row_vector_matrix_transform.sv =====
// ----------------------------------------------------------------------------
// row_vector_matrix_transform
// Signed fixed-point row vector times a 4x4 matrix held in registers.
// ----------------------------------------------------------------------------
// Takes one vector per clock and returns one result per clock for as long as
// the output is not stalled. On the way from input transaction to output valid,
// the product register of each of the four column lanes loads at the accepting
// edge, then a pairwise-sum stage, a total/shift/clip stage and the output
// register follow. Each result element is the exact sum of v[k]*M[k][c],
// shifted right by FRAC_BITS with rounding toward minus infinity and clipped
// to 32 bits; saturated flags any clipped element. The matrix resets to
// identity; it must be written through the cfg port only while no transaction
// is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module row_vector_matrix_transform #(
  parameter int FRAC_BITS = rvmt_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rvmt_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rvmt_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [rvmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rvmt_pkg::CFG_W-1:0]       cfg_data
);
  import rvmt_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_ROW0_XY = 0;
  localparam logic [REG_IDX_W-1:0] REG_ROW0_ZW = 1;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_XY = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_ZW = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_XY = 4;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_ZW = 5;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_XY = 6;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_ZW = 7;
  localparam logic [ELEM_W-1:0]    ONE         = ELEM_W'(1) << FRAC_BITS;

  logic [CFG_W-1:0] mat [NUM_REGS];
  vec_t             vec;
  vec_t             coef [VEC_LEN];
  lane_res_t        res  [VEC_LEN];
  lane_ctl_t        ctl;
  logic             v1, v2, v3;
  logic             r1, r2, r3;
  logic             m_ready;

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mat[REG_ROW0_XY] <= {{ELEM_W{1'b0}}, ONE};
      mat[REG_ROW0_ZW] <= '0;
      mat[REG_ROW1_XY] <= {ONE, {ELEM_W{1'b0}}};
      mat[REG_ROW1_ZW] <= '0;
      mat[REG_ROW2_XY] <= '0;
      mat[REG_ROW2_ZW] <= {{ELEM_W{1'b0}}, ONE};
      mat[REG_ROW3_XY] <= '0;
      mat[REG_ROW3_ZW] <= {ONE, {ELEM_W{1'b0}}};
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      mat[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign vec[0] = in_data.in_x;
  assign vec[1] = in_data.in_y;
  assign vec[2] = in_data.in_z;
  assign vec[3] = in_data.in_w;

  // lane c takes column c: M[k][c] sits in register 2k + c/2, half c%2
  for (genvar c = 0; c < VEC_LEN; c++) begin : g_lane
    for (genvar k = 0; k < VEC_LEN; k++) begin : g_coef
      assign coef[c][k] = mat[2*k + c/2][(c%2)*ELEM_W +: ELEM_W];
    end

    rvmt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .vec  (vec),
      .coef (coef[c]),
      .res  (res[c])
    );
  end

  // a stage moves on when it is empty or the next one moves on
  assign r3       = !v3 || m_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_stall = !r1;
  assign ctl.en1  = r1;
  assign ctl.en2  = r2;
  assign ctl.en3  = r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  rvmt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .res_valid (v3),
    .res       (res),
    .ready     (m_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted transaction not held in the first stage");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    v3 && !out_valid |=> out_valid)
    else $error("finished transaction not moved to an empty output");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v3))
    else $error("output valid without a finished lane result");

endmodule

// ===== hdl/rvmt_lane.sv =====
// ----------------------------------------------------------------------------
// rvmt_lane
// One output column: four products, pairwise sums, total, shift and clip.
// ----------------------------------------------------------------------------
module rvmt_lane #(
  parameter int FRAC_BITS = rvmt_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  rvmt_pkg::lane_ctl_t   ctl,
  input  rvmt_pkg::vec_t        vec,
  input  rvmt_pkg::vec_t        coef,
  output rvmt_pkg::lane_res_t   res
);
  import rvmt_pkg::*;

  localparam int NPAIR = VEC_LEN / 2;

  logic signed [PROD_W-1:0] prod [VEC_LEN];
  logic signed [PROD_W:0]   pair [NPAIR];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic [SUM_W-ELEM_W:0]    upper;
  lane_res_t                res_next;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      for (int k = 0; k < VEC_LEN; k++) begin
        prod[k] <= $signed(vec[k]) * $signed(coef[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      for (int j = 0; j < NPAIR; j++) begin
        pair[j] <= (PROD_W+1)'(prod[2*j]) + (PROD_W+1)'(prod[2*j+1]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < NPAIR; j++) begin
      sum = sum + SUM_W'(pair[j]);
    end
    // floor shift, then the result fits only if the upper bits are all sign
    shifted = sum >>> FRAC_BITS;
    upper   = shifted[SUM_W-1:ELEM_W-1];
    if (upper == '0 || upper == '1) begin
      res_next.value = shifted[ELEM_W-1:0];
      res_next.sat   = 1'b0;
    end else begin
      res_next.value = shifted[SUM_W-1] ? ELEM_MIN : ELEM_MAX;
      res_next.sat   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/rvmt_merge.sv =====
// ----------------------------------------------------------------------------
// rvmt_merge
// Gathers the four lane results into one output transaction and holds it.
// ----------------------------------------------------------------------------
module rvmt_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  rvmt_pkg::lane_res_t res [rvmt_pkg::VEC_LEN],
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output rvmt_pkg::out_t      out_data
);
  import rvmt_pkg::*;

  logic any_sat;

  assign ready = !out_valid || !out_stall;

  always_comb begin
    any_sat = 1'b0;
    for (int c = 0; c < VEC_LEN; c++) begin
      any_sat = any_sat | res[c].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res_valid) begin
      out_data.out_x     <= res[0].value;
      out_data.out_y     <= res[1].value;
      out_data.out_z     <= res[2].value;
      out_data.out_w     <= res[3].value;
      out_data.saturated <= any_sat;
    end
  end

endmodule

// ===== dv/tb_row_vector_matrix_transform.sv =====
// ----------------------------------------------------------------------------
// tb_row_vector_matrix_transform
// Self-checking bench for the row-vector by 4x4 matrix transform.
// ----------------------------------------------------------------------------
// A directed table covers identity after reset, field extremes, writes to
// unused register indexes, exact and clipped limits and floor rounding. It is
// followed by random phases, each with a fresh matrix. Every accepted vector
// is scored against its table result or a local fixed-point model of the
// transform. Both sides idle in random bursts, except in the last phase. The
// receiver holds off once for a long stretch, and the sender once drains the pipe mid-phase.
// ----------------------------------------------------------------------------
module tb_row_vector_matrix_transform;
  import rvmt_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int RESET_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 140;
  localparam int MAX_REPORTS    = 10;

  localparam elem_t FX_MAX     = elem_t'(ELEM_MAX);
  localparam elem_t FX_MIN     = elem_t'(ELEM_MIN);
  localparam elem_t FX_ONE     = elem_t'(1 << FRAC);
  localparam elem_t FX_NEG_ONE = -FX_ONE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_XY, REG_ROW0_ZW, REG_ROW1_XY, REG_ROW1_ZW,
    REG_ROW2_XY, REG_ROW2_ZW, REG_ROW3_XY, REG_ROW3_ZW
  } mat_reg_e;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    in_t                  vec;
    bit                   typed;
    out_t                 result;
  } stim_row_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // expectation travelling with the vector on offer
  bit   cur_typed  = 1'b0;
  out_t cur_result = '0;

  logic [CFG_W-1:0] mat_shadow [NUM_REGS];
  out_t             transformed_q [$];
  stim_row_t        stim_table [$];
  int unsigned      mismatch_cnt = 0;
  int unsigned      quiet_cycles = 0;
  bit               no_idle      = 1'b0;
  bit               hold_armed   = 1'b0;
  bit               hold_done    = 1'b0;
  int unsigned      hold_left    = 0;
  int unsigned      stall_left   = 0;
  int unsigned      gap_left     = 0;

  row_vector_matrix_transform #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic elem_t matrix_elem(int row, int col);
    logic [CFG_W-1:0] r;
    r = mat_shadow[row * 2 + col / 2];
    return (col % 2) ? elem_t'(r[63:32]) : elem_t'(r[31:0]);
  endfunction

  // exact sum of products, floor shift, clip to 32 bits
  function automatic out_t transform_vector(in_t v);
    elem_t                comp [VEC_LEN];
    elem_t                col_res [VEC_LEN];
    logic signed [71:0]   acc, wa, wb, q, hi_lim, lo_lim;
    out_t                 r;
    comp[0] = v.in_x;
    comp[1] = v.in_y;
    comp[2] = v.in_z;
    comp[3] = v.in_w;
    hi_lim = FX_MAX;
    lo_lim = FX_MIN;
    r = '0;
    for (int c = 0; c < VEC_LEN; c++) begin
      acc = '0;
      for (int k = 0; k < VEC_LEN; k++) begin
        wa = comp[k];
        wb = matrix_elem(k, c);
        acc = acc + wa * wb;
      end
      q = acc >>> FRAC;
      if (q > hi_lim) begin
        col_res[c] = FX_MAX;
        r.saturated = 1'b1;
      end else if (q < lo_lim) begin
        col_res[c] = FX_MIN;
        r.saturated = 1'b1;
      end else begin
        col_res[c] = q[31:0];
      end
    end
    r.out_x = col_res[0];
    r.out_y = col_res[1];
    r.out_z = col_res[2];
    r.out_w = col_res[3];
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pair(elem_t lo, elem_t hi);
    return {hi, lo};
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, vec: '0, typed: 1'b0, result: '0};
    stim_table.push_back(row);
  endfunction

  function automatic void add_vec(in_t v, bit typed, out_t r);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, data: '0, vec: v, typed: typed, result: r};
    stim_table.push_back(row);
  endfunction

  function automatic void fill_matrix(elem_t e);
    for (int i = 0; i < NUM_REGS; i++) add_cfg(CFG_IDX_W'(i), pair(e, e));
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0:       return FX_MAX;
      1:       return FX_MIN;
      2:       return '0;
      3:       return FX_ONE;
      4:       return FX_NEG_ONE;
      5, 6:    return elem_t'($urandom_range(0, 32'h0008_0000)) - elem_t'(32'h0004_0000);
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic elem_t rand_comp();
    case ($urandom_range(0, 7))
      0:       return FX_MAX;
      1:       return FX_MIN;
      2, 3:    return elem_t'($urandom_range(0, 32'h0020_0000)) - elem_t'(32'h0010_0000);
      4:       return elem_t'($urandom_range(0, 32'h0000_0100)) - elem_t'(32'h0000_0080);
      default: return elem_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx < NUM_REGS) mat_shadow[idx[REG_IDX_W-1:0]] = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (transformed_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_vec(in_t v, bit typed, out_t r);
    if (!no_idle && gap_left == 0 && $urandom_range(0, 5) == 0)
      gap_left = $urandom_range(1, 8);
    while (gap_left > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap_left--;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_data    <= v;
    cur_typed  <= typed;
    cur_result <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // receiver: one long hold-off when armed, otherwise random stall bursts, none while no_idle is set
  always @(negedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // scoreboard and watchdog
  always @(posedge clk) begin
    out_t exp_res;
    bit   busy;
    if (!rst) begin
      busy = cfg_we;
      if (in_valid && !in_stall) begin
        transformed_q.push_back(cur_typed ? cur_result : transform_vector(in_data));
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (transformed_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result transaction: x=%h y=%h z=%h w=%h sat=%b",
                     out_data.out_x, out_data.out_y, out_data.out_z, out_data.out_w,
                     out_data.saturated);
        end else begin
          exp_res = transformed_q.pop_front();
          if (out_data.out_x !== exp_res.out_x || out_data.out_y !== exp_res.out_y ||
              out_data.out_z !== exp_res.out_z || out_data.out_w !== exp_res.out_w ||
              out_data.saturated !== exp_res.saturated) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("mismatch: exp x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
                       exp_res.out_x, exp_res.out_y, exp_res.out_z, exp_res.out_w,
                       exp_res.saturated, out_data.out_x, out_data.out_y,
                       out_data.out_z, out_data.out_w, out_data.saturated);
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL row_vector_matrix_transform");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    in_t       v;
    for (int i = 0; i < NUM_REGS; i++) mat_shadow[i] = '0;
    mat_shadow[REG_ROW0_XY] = pair(FX_ONE, '0);
    mat_shadow[REG_ROW1_XY] = pair('0, FX_ONE);
    mat_shadow[REG_ROW2_ZW] = pair(FX_ONE, '0);
    mat_shadow[REG_ROW3_ZW] = pair('0, FX_ONE);

    // identity after reset passes vectors through untouched
    add_vec(in_t'{FX_ONE, 32'sh0002_0000, 32'shFFFD_0000, 32'sh0000_8000}, 1'b1,
            out_t'{FX_ONE, 32'sh0002_0000, 32'shFFFD_0000, 32'sh0000_8000, 1'b0});
    add_vec(in_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX}, 1'b1,
            out_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0});
    add_vec(in_t'{FX_MIN, FX_MIN, FX_MIN, FX_MIN}, 1'b1,
            out_t'{FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0});
    add_vec(in_t'{FX_MAX, FX_MIN, 32'sh0, -32'sh1}, 1'b1,
            out_t'{FX_MAX, FX_MIN, 32'sh0, -32'sh1, 1'b0});
    // writes to unused indexes must leave the matrix alone
    add_cfg(REG_UNUSED_FIRST, '1);
    add_cfg(REG_UNUSED_LAST, 64'h5555_5555_AAAA_AAAA);
    add_vec(in_t'{32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0, 32'sh7F00_00FF}, 1'b1,
            out_t'{32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0, 32'sh7F00_00FF, 1'b0});

    // all elements at the positive limit
    fill_matrix(FX_MAX);
    add_vec(in_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX}, 1'b1,
            out_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1});
    add_vec(in_t'{FX_MIN, FX_MIN, FX_MIN, FX_MIN}, 1'b1,
            out_t'{FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1});
    add_vec(in_t'{FX_ONE, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
            out_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0});
    add_vec(in_t'{FX_ONE, 32'sh1, 32'sh0, 32'sh0}, 1'b0, '0);
    add_vec(in_t'{32'sh1, 32'sh0, 32'sh0, 32'sh0}, 1'b0, '0);

    // smallest element: floor rounding of tiny sums
    fill_matrix(32'sh1);
    add_vec(in_t'{-32'sh1, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
            out_t'{-32'sh1, -32'sh1, -32'sh1, -32'sh1, 1'b0});
    add_vec(in_t'{32'sh0000_FFFF, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
            out_t'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0});
    add_vec(in_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX}, 1'b0, '0);

    // all elements at the negative limit
    fill_matrix(FX_MIN);
    add_vec(in_t'{FX_MIN, FX_MIN, FX_MIN, FX_MIN}, 1'b1,
            out_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1});
    add_vec(in_t'{FX_MAX, FX_MAX, FX_MAX, FX_MAX}, 1'b1,
            out_t'{FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1});
    add_vec(in_t'{FX_ONE, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
            out_t'{FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0});
    add_vec(in_t'{32'sh1, 32'sh0, 32'sh0, 32'sh0}, 1'b0, '0);

    // quarter turn about z with a translation
    add_cfg(REG_ROW0_XY, pair('0, FX_ONE));
    add_cfg(REG_ROW0_ZW, '0);
    add_cfg(REG_ROW1_XY, pair(FX_NEG_ONE, '0));
    add_cfg(REG_ROW1_ZW, '0);
    add_cfg(REG_ROW2_XY, '0);
    add_cfg(REG_ROW2_ZW, pair(FX_ONE, '0));
    add_cfg(REG_ROW3_XY, pair(32'sh0003_8000, -32'sh0001_4000));
    add_cfg(REG_ROW3_ZW, pair(32'sh0000_C000, FX_ONE));
    add_vec(in_t'{FX_ONE, 32'sh0002_0000, 32'sh0003_0000, FX_ONE}, 1'b0, '0);
    add_vec(in_t'{-32'sh0000_8000, 32'sh0010_0001, -32'sh0007_3333, FX_ONE}, 1'b0, '0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_cfg) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        send_vec(row.vec, row.typed, row.result);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p == NUM_PHASES - 1) no_idle = 1'b1;
      for (int i = 0; i < NUM_REGS; i++)
        write_reg(CFG_IDX_W'(i), pair(rand_elem(), rand_elem()));
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                {$urandom, $urandom});
      // long receiver hold-off while vectors keep coming, fills the pipe
      if (p == 1) hold_armed = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) wait_drained();
        v.in_x = rand_comp();
        v.in_y = rand_comp();
        v.in_z = rand_comp();
        v.in_w = rand_comp();
        send_vec(v, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS row_vector_matrix_transform");
    end else begin
      $display("FAIL row_vector_matrix_transform");
    end
    $finish;
  end

endmodule

// ===== row_vector_matrix_transform.f =====
hdl/rvmt_pkg.sv
hdl/rvmt_lane.sv
hdl/rvmt_merge.sv
hdl/row_vector_matrix_transform.sv
dv/tb_row_vector_matrix_transform.sv
